[rtl/core/chtbl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtbl_pkg
// Shared widths, codes and types of the coordinate hash table.
// ----------------------------------------------------------------------------
package chtbl_pkg;

  localparam int FUNC_W      = 2;
  localparam int SITE_W      = 12;
  localparam int COORD_W     = 20;
  localparam int STATUS_W    = 2;
  localparam int ROW_KEY_W   = 7;
  localparam int COL_KEY_W   = 6;
  localparam int CFG_W       = 8;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  // fixed point: integer cell = coord / 10000, fraction digits = coord % 10000
  localparam int CELL_W      = 7;
  localparam int FRACD_W     = 14;
  localparam int STRIDE_W    = 2 * CFG_W;
  localparam int LIN_W       = 23;
  localparam int FRAC_W      = 27;
  localparam int FRAC_ONE    = 10000;
  localparam int FRAC_SHIFT  = 23;
  localparam int FRAC_RECIP_W = 10;
  localparam logic [FRAC_RECIP_W-1:0] FRAC_RECIP = FRAC_RECIP_W'((1 << FRAC_SHIFT) / FRAC_ONE);
  localparam int WEIGHT_Y    = 100;
  localparam int WEIGHT_Z    = 10000;

  localparam int SITE_LIMIT  = 4096;

  localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_COLLIDE = 2'd1;
  localparam logic [STATUS_W-1:0] STS_MISS    = 2'd2;

  localparam logic REG_CELLS_X = 1'b0;
  localparam logic REG_CELLS_Y = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] cells_x;
    logic [CFG_W-1:0] cells_y;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [SITE_W-1:0]    found_index;
    logic [ROW_KEY_W-1:0] row_key;
    logic [COL_KEY_W-1:0] col_key;
  } rsp_t;

  typedef enum logic [1:0] {
    BK_INIT,
    BK_IDLE,
    BK_CHECK,
    BK_CLEAR
  } back_state_t;

endpackage

[rtl/core/coordinate_hash_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coordinate_hash_table
// Hash table from fixed-point atom coordinates to site indices.
// Insert/lookup path: 6 key stages, then the queue, then the table sequencer.
// The sequencer takes a new insert or lookup only after the slot memory
// read-check-write of the last one, and only while the result register is free.
// Clear sweeps all ROW_MOD*COL_MOD slots, one slot written per cycle. After reset the same
// sweep runs with req_stall high; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module coordinate_hash_table #(
  parameter int ROW_MOD = 127,
  parameter int COL_MOD = 61
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [chtbl_pkg::PADDR_W-1:0]      paddr,
  input  logic [chtbl_pkg::PDATA_W-1:0]      pwdata,
  output logic [chtbl_pkg::PDATA_W-1:0]      prdata,
  output logic                               pready,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic [chtbl_pkg::FUNC_W-1:0]       func,
  input  logic [chtbl_pkg::SITE_W-1:0]       site_index,
  input  logic [chtbl_pkg::COORD_W-1:0]      coord_x,
  input  logic [chtbl_pkg::COORD_W-1:0]      coord_y,
  input  logic [chtbl_pkg::COORD_W-1:0]      coord_z,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic [chtbl_pkg::STATUS_W-1:0]     status,
  output logic [chtbl_pkg::SITE_W-1:0]       found_index,
  output logic [chtbl_pkg::ROW_KEY_W-1:0]    row_key,
  output logic [chtbl_pkg::COL_KEY_W-1:0]    col_key
);
  import chtbl_pkg::*;

  localparam int ADDR_W      = $clog2(ROW_MOD * COL_MOD);
  localparam int QW          = FUNC_W + SITE_W + ROW_KEY_W + COL_KEY_W + ADDR_W;
  localparam int QUEUE_DEPTH = 4;

  cfg_t            cfg;
  rsp_t            rsp;
  logic            init_busy;
  logic            q_push, q_pop, q_full, q_not_empty;
  logic [QW-1:0]   q_in, q_head;
  logic            reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cells_x <= CFG_W'(1);
      cfg.cells_y <= CFG_W'(1);
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_CELLS_X: cfg.cells_x <= pwdata[CFG_W-1:0];
        REG_CELLS_Y: cfg.cells_y <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CELLS_X: prdata = PDATA_W'(cfg.cells_x);
      REG_CELLS_Y: prdata = PDATA_W'(cfg.cells_y);
      default:     prdata = '0;
    endcase
  end

  chtbl_front #(
    .ROW_MOD (ROW_MOD),
    .COL_MOD (COL_MOD),
    .ADDR_W  (ADDR_W),
    .QW      (QW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .init_busy  (init_busy),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .func       (func),
    .site_index (site_index),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  chtbl_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  chtbl_back #(
    .ROW_MOD (ROW_MOD),
    .COL_MOD (COL_MOD),
    .ADDR_W  (ADDR_W),
    .QW      (QW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_not_empty),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  assign status      = rsp.status;
  assign found_index = rsp.found_index;
  assign row_key     = rsp.row_key;
  assign col_key     = rsp.col_key;

endmodule

[rtl/core/chtbl_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtbl_front
// Six-stage key pipeline: splits coordinates, linearises, reduces both keys
// and the slot address, then pushes one queue entry per beat.
// ----------------------------------------------------------------------------
module chtbl_front #(
  parameter int ROW_MOD = 127,
  parameter int COL_MOD = 61,
  parameter int ADDR_W  = 13,
  parameter int QW      = 40
) (
  input  logic                            clk,
  input  logic                            rst,
  input  chtbl_pkg::cfg_t                 cfg,
  input  logic                            init_busy,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [chtbl_pkg::FUNC_W-1:0]    func,
  input  logic [chtbl_pkg::SITE_W-1:0]    site_index,
  input  logic [chtbl_pkg::COORD_W-1:0]   coord_x,
  input  logic [chtbl_pkg::COORD_W-1:0]   coord_y,
  input  logic [chtbl_pkg::COORD_W-1:0]   coord_z,
  input  logic                            q_full,
  output logic                            q_push,
  output logic [QW-1:0]                   q_data
);
  import chtbl_pkg::*;

  localparam int ROW_W = $clog2(ROW_MOD);
  localparam int COL_W = $clog2(COL_MOD);
  localparam int SPLIT_PW = COORD_W + FRAC_RECIP_W;
  localparam logic [LIN_W-1:0]  ROW_RECIP = LIN_W'((64'd1 << LIN_W) / ROW_MOD);
  localparam logic [FRAC_W-1:0] COL_RECIP = FRAC_W'((64'd1 << FRAC_W) / COL_MOD);

  function automatic logic [CELL_W-1:0] quot_est(input logic [COORD_W-1:0] c);
    logic [SPLIT_PW-1:0] p;
    p = SPLIT_PW'(c) * SPLIT_PW'(FRAC_RECIP);
    return p[FRAC_SHIFT +: CELL_W];
  endfunction

  function automatic logic [CELL_W+FRACD_W-1:0] split_fix(input logic [COORD_W-1:0] c,
                                                           input logic [CELL_W-1:0] q0);
    logic [COORD_W-1:0] r;
    logic [CELL_W-1:0]  q;
    r = c - COORD_W'(q0) * COORD_W'(FRAC_ONE);
    q = q0;
    if (r >= COORD_W'(FRAC_ONE)) begin
      r = r - COORD_W'(FRAC_ONE);
      q = q0 + 1'b1;
    end
    return {q, FRACD_W'(r)};
  endfunction

  logic advance, accept;
  logic v1, v2, v3, v4, v5, v6;

  logic [FUNC_W-1:0] f1, f2, f3, f4, f5, f6;
  logic [SITE_W-1:0] s1, s2, s3, s4, s5, s6;

  logic [COORD_W-1:0] cx1, cy1, cz1;
  logic [CELL_W-1:0]  qx1, qy1, qz1;
  logic [CELL_W-1:0]  ix2, iy2, iz2;
  logic [FRACD_W-1:0] fx2, fy2, fz2;
  logic [LIN_W-1:0]   lin3, lin4;
  logic [FRAC_W-1:0]  frac3, frac4;
  logic [LIN_W-1:0]   rq4;
  logic [FRAC_W-1:0]  cq4;
  logic [ROW_W-1:0]   row5;
  logic [COL_W-1:0]   col5;
  logic [ROW_KEY_W-1:0] rk6;
  logic [COL_KEY_W-1:0] ck6;
  logic [ADDR_W-1:0]  addr6;
  logic [STRIDE_W-1:0] sxy;

  logic [CELL_W+FRACD_W-1:0] spx, spy, spz;
  logic [2*LIN_W-1:0]  rprod;
  logic [2*FRAC_W-1:0] cprod;
  logic [LIN_W-1:0]    rdiff;
  logic [FRAC_W-1:0]   cdiff;

  assign advance   = !(v6 && q_full);
  assign req_stall = !advance || init_busy;
  assign accept    = req_valid && !req_stall;
  assign q_push    = v6 && !q_full;
  assign q_data    = {f6, s6, rk6, ck6, addr6};

  assign spx   = split_fix(cx1, qx1);
  assign spy   = split_fix(cy1, qy1);
  assign spz   = split_fix(cz1, qz1);
  assign rprod = (2*LIN_W)'(lin3) * (2*LIN_W)'(ROW_RECIP);
  assign cprod = (2*FRAC_W)'(frac3) * (2*FRAC_W)'(COL_RECIP);
  assign rdiff = lin4 - LIN_W'(rq4 * LIN_W'(ROW_MOD));
  assign cdiff = frac4 - FRAC_W'(cq4 * FRAC_W'(COL_MOD));

  always_ff @(posedge clk) begin
    sxy <= STRIDE_W'(cfg.cells_x) * STRIDE_W'(cfg.cells_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6} <= '0;
    end else if (advance) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f1  <= func;
      s1  <= site_index;
      cx1 <= coord_x;
      cy1 <= coord_y;
      cz1 <= coord_z;
      qx1 <= quot_est(coord_x);
      qy1 <= quot_est(coord_y);
      qz1 <= quot_est(coord_z);

      f2 <= f1;
      s2 <= s1;
      {ix2, fx2} <= spx;
      {iy2, fy2} <= spy;
      {iz2, fz2} <= spz;

      f3    <= f2;
      s3    <= s2;
      lin3  <= LIN_W'(ix2) + LIN_W'(iy2) * LIN_W'(cfg.cells_x) + LIN_W'(iz2) * LIN_W'(sxy);
      frac3 <= FRAC_W'(fx2) + FRAC_W'(fy2) * FRAC_W'(WEIGHT_Y)
             + FRAC_W'(fz2) * FRAC_W'(WEIGHT_Z);

      f4    <= f3;
      s4    <= s3;
      lin4  <= lin3;
      frac4 <= frac3;
      rq4   <= rprod[LIN_W +: LIN_W];
      cq4   <= cprod[FRAC_W +: FRAC_W];

      f5   <= f4;
      s5   <= s4;
      row5 <= (rdiff >= LIN_W'(ROW_MOD)) ? ROW_W'(rdiff - LIN_W'(ROW_MOD)) : ROW_W'(rdiff);
      col5 <= (cdiff >= FRAC_W'(COL_MOD)) ? COL_W'(cdiff - FRAC_W'(COL_MOD)) : COL_W'(cdiff);

      f6    <= f5;
      s6    <= s5;
      rk6   <= ROW_KEY_W'(row5);
      ck6   <= COL_KEY_W'(col5);
      addr6 <= ADDR_W'(ADDR_W'(row5) * ADDR_W'(COL_MOD)) + ADDR_W'(col5);
    end
  end

endmodule

[rtl/core/chtbl_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtbl_fifo
// Short register queue between the key pipeline and the table sequencer.
// ----------------------------------------------------------------------------
module chtbl_fifo #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             not_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

[rtl/core/chtbl_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtbl_back
// Table sequencer: slot memory, read-check-write per beat, clear sweep,
// result register.
// ----------------------------------------------------------------------------
module chtbl_back #(
  parameter int ROW_MOD = 127,
  parameter int COL_MOD = 61,
  parameter int ADDR_W  = 13,
  parameter int QW      = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  logic [QW-1:0]     q_data,
  output logic              q_pop,
  output logic              init_busy,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output chtbl_pkg::rsp_t   rsp
);
  import chtbl_pkg::*;

  localparam int SLOT_COUNT = ROW_MOD * COL_MOD;
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(SLOT_COUNT - 1);

  logic [SITE_W:0] mem [SLOT_COUNT];

  back_state_t state, state_next;
  logic [ADDR_W-1:0]    ptr;
  logic [SITE_W:0]      rdata;
  logic [FUNC_W-1:0]    cur_func;
  logic [SITE_W-1:0]    cur_site;
  logic [ROW_KEY_W-1:0] cur_row;
  logic [COL_KEY_W-1:0] cur_col;
  logic [ADDR_W-1:0]    cur_addr;

  logic [FUNC_W-1:0]    hd_func;
  logic [ADDR_W-1:0]    hd_addr;
  logic                 out_free, sweeping, sweep_last, hit;
  logic                 we, rsp_load;
  logic [ADDR_W-1:0]    waddr;
  logic [SITE_W:0]      wdata;
  rsp_t                 rsp_next;

  assign hd_addr    = q_data[ADDR_W-1:0];
  assign hd_func    = q_data[ADDR_W + COL_KEY_W + ROW_KEY_W + SITE_W +: FUNC_W];
  assign out_free   = !rsp_valid || !rsp_stall;
  assign sweeping   = (state == BK_INIT) || (state == BK_CLEAR);
  assign sweep_last = (ptr == LAST_SLOT);
  assign hit        = rdata[SITE_W];
  assign init_busy  = (state == BK_INIT);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_INIT: begin
        if (sweep_last) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        if (q_valid && out_free) begin
          state_next = (hd_func == FN_CLEAR) ? BK_CLEAR : BK_CHECK;
        end
      end
      BK_CHECK: begin
        state_next = BK_IDLE;
      end
      BK_CLEAR: begin
        if (sweep_last) state_next = BK_IDLE;
      end
      default: state_next = BK_INIT;
    endcase
  end

  always_comb begin
    q_pop    = (state == BK_IDLE) && q_valid && out_free;
    we       = sweeping;
    waddr    = ptr;
    wdata    = '0;
    rsp_load = 1'b0;
    rsp_next.status      = STS_OK;
    rsp_next.found_index = '0;
    rsp_next.row_key     = cur_row;
    rsp_next.col_key     = cur_col;
    if (state == BK_CLEAR && sweep_last) begin
      rsp_load = 1'b1;
    end
    if (state == BK_CHECK) begin
      rsp_load = 1'b1;
      unique case (cur_func)
        FN_INSERT: begin
          if (32'(cur_site) >= SITE_LIMIT || hit) begin
            rsp_next.status = STS_COLLIDE;
          end else begin
            we    = 1'b1;
            waddr = cur_addr;
            wdata = {1'b1, cur_site};
          end
        end
        FN_LOOKUP: begin
          if (hit) begin
            rsp_next.found_index = rdata[SITE_W-1:0];
          end else begin
            rsp_next.status = STS_MISS;
          end
        end
        default: rsp_next.status = STS_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_INIT;
      ptr       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (sweeping) begin
        ptr <= sweep_last ? '0 : ptr + 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      {cur_func, cur_site, cur_row, cur_col, cur_addr} <= q_data;
      rdata <= mem[hd_addr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == BK_CHECK) |-> !rsp_valid)
    else $error("result computed while output register still full");

  a_init_once: assert property (@(posedge clk) disable iff (rst)
    !init_busy |=> !init_busy)
    else $error("reset sweep restarted");

  a_ptr_home: assert property (@(posedge clk) disable iff (rst)
    (state == BK_IDLE) |-> (ptr == '0))
    else $error("sweep pointer not parked");

  a_insert_empty: assert property (@(posedge clk) disable iff (rst)
    (we && state == BK_CHECK) |-> !hit)
    else $error("insert overwrote an occupied slot");

  a_pop_next: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == BK_CHECK || state == BK_CLEAR))
    else $error("popped beat not carried out");
`endif

endmodule
